// ----- hw/rtl/pfsa_pkg.sv -----
// Shared definitions for the page frame stack allocator.
// Holds default sizes, operation and status codes, and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfsa_pkg;

  localparam int STACK_DEPTH_DEF      = 1024;
  localparam int MAX_REGIONS_DEF      = 32;
  localparam int PAGE_NUMBER_BITS_DEF = 40;

  localparam int TYPE_BITS   = 4;
  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;

  localparam logic [TYPE_BITS-1:0] USABLE_TYPE_RST = 4'd7;

  localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_BITS-1:0] OP_FREE  = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_OOM        = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_STACK_FULL = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_TABLE_FULL = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic idle;
    logic stack_rd;
    logic do_op;
    logic scan_start;
    logic tbl_rd;
    logic calc;
    logic clamp;
    logic push;
    logic next_region;
  } pfsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic accepted;
    logic op_alloc;
    logic fill_zero;
    logic fill_full;
    logic slot_free;
    logic scan_end;
    logic push_ok;
  } pfsa_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pfsa_if.sv -----
// Request and response channel interfaces of the page frame stack allocator.
// Depends on pfsa_pkg for field widths and defaults.
`timescale 1ns / 1ps
`default_nettype none

interface pfsa_in_if import pfsa_pkg::*; #(
  parameter int PNB = PAGE_NUMBER_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [OP_BITS-1:0]   op;
  logic [PNB-1:0]       page_number;
  logic [TYPE_BITS-1:0] region_type;
  logic [PNB-1:0]       region_base;
  logic [PNB-1:0]       region_pages;

  modport source (output valid, op, page_number, region_type, region_base, region_pages,
                  input ready);
  modport sink (input valid, op, page_number, region_type, region_base, region_pages,
                output ready);
endinterface

interface pfsa_out_if import pfsa_pkg::*; #(
  parameter int PNB = PAGE_NUMBER_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [PNB-1:0]         granted_page;
  logic [STATUS_BITS-1:0] status;

  modport source (output valid, granted_page, status, input ready);
  modport sink (input valid, granted_page, status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pfsa_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pfsa_dp.sv -----
// Datapath of the page frame stack allocator: stack and region memories, counters,
// refill cursor, request latch and response register. Depends on pfsa_pkg, pfsa_if, pfsa_ram.
`timescale 1ns / 1ps
`default_nettype none

module pfsa_dp import pfsa_pkg::*; #(
  parameter int STACK_DEPTH      = STACK_DEPTH_DEF,
  parameter int MAX_REGIONS      = MAX_REGIONS_DEF,
  parameter int PAGE_NUMBER_BITS = PAGE_NUMBER_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [TYPE_BITS-1:0] cfg_wdata,
  pfsa_in_if.sink                   req,
  pfsa_out_if.source                rsp,
  input  wire pfsa_cmd_t            cmd,
  output pfsa_sts_t                 sts
);

  localparam int PW  = PAGE_NUMBER_BITS;
  localparam int CW  = PW + 1;
  localparam int SFW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int TUW = $clog2(MAX_REGIONS + 1);
  localparam int TAW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam logic [CW-1:0] LIMIT = {1'b1, {PW{1'b0}}};

  logic [TYPE_BITS-1:0] usable_type;
  logic [OP_BITS-1:0]   op_q;
  logic [PW-1:0]        page_q;
  logic [TYPE_BITS-1:0] type_q;
  logic [PW-1:0]        base_q;
  logic [PW-1:0]        pages_q;

  logic [SFW-1:0] fill;
  logic [TUW-1:0] used;
  logic [TUW-1:0] ridx;
  logic [CW-1:0]  cursor;
  logic [CW-1:0]  lo;
  logic [CW-1:0]  hi;

  logic                   out_valid;
  logic [PW-1:0]          granted;
  logic [STATUS_BITS-1:0] status;

  logic            accepted;
  logic            fill_zero;
  logic            fill_full;
  logic            table_full;
  logic            type_match;
  logic [SFW-1:0]  fill_dec;
  logic [CW-1:0]   lo_inc;
  logic [CW-1:0]   region_end;
  logic [PW-1:0]   tbl_base;
  logic [PW-1:0]   tbl_pages;

  logic            stk_we;
  logic [PW-1:0]   stk_wdata;
  logic [PW-1:0]   stk_rdata;
  logic            tbl_we;
  logic [2*PW-1:0] tbl_rdata;

  assign req.ready  = cmd.idle;
  assign accepted   = req.valid && cmd.idle;
  assign fill_zero  = (fill == '0);
  assign fill_full  = (fill == SFW'(STACK_DEPTH));
  assign table_full = (used == TUW'(MAX_REGIONS));
  assign type_match = (type_q == usable_type);
  assign fill_dec   = fill - SFW'(1);
  assign lo_inc     = lo + CW'(1);

  assign tbl_base   = tbl_rdata[2*PW-1:PW];
  assign tbl_pages  = tbl_rdata[PW-1:0];
  assign region_end = {1'b0, tbl_base} + {1'b0, tbl_pages};

  assign sts.accepted  = accepted;
  assign sts.op_alloc  = (op_q == OP_ALLOC);
  assign sts.fill_zero = fill_zero;
  assign sts.fill_full = fill_full;
  assign sts.slot_free = !out_valid || rsp.ready;
  assign sts.scan_end  = (ridx == used);
  assign sts.push_ok   = (lo < hi) && !fill_full;

  assign stk_we    = (cmd.do_op && op_q == OP_FREE && !fill_full) || cmd.push;
  assign stk_wdata = cmd.push ? lo[PW-1:0] : page_q;
  assign tbl_we    = cmd.do_op && op_q == OP_LOAD && type_match && !table_full;

  pfsa_ram #(
    .WIDTH (PW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (fill[SAW-1:0]),
    .wdata (stk_wdata),
    .re    (cmd.stack_rd),
    .raddr (fill_dec[SAW-1:0]),
    .rdata (stk_rdata)
  );

  pfsa_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_REGIONS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (used[TAW-1:0]),
    .wdata ({base_q, pages_q}),
    .re    (cmd.tbl_rd),
    .raddr (ridx[TAW-1:0]),
    .rdata (tbl_rdata)
  );

  // Request latch and the window bounds of the region being scanned.
  always_ff @(posedge clk) begin
    if (accepted) begin
      op_q    <= req.op;
      page_q  <= req.page_number;
      type_q  <= req.region_type;
      base_q  <= req.region_base;
      pages_q <= req.region_pages;
    end
    if (cmd.calc) begin
      lo <= {1'b0, tbl_base};
      hi <= (region_end > LIMIT) ? LIMIT : region_end;
    end else if (cmd.clamp) begin
      if (lo < cursor) begin
        lo <= cursor;
      end
    end else if (cmd.push) begin
      lo <= lo_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_type <= USABLE_TYPE_RST;
      fill        <= '0;
      used        <= '0;
      ridx        <= '0;
      cursor      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        usable_type <= cfg_wdata;
      end
      if (cmd.scan_start) begin
        ridx <= '0;
      end else if (cmd.next_region) begin
        ridx <= ridx + TUW'(1);
      end
      if (cmd.push) begin
        fill   <= fill + SFW'(1);
        cursor <= lo_inc;
      end
      if (cmd.do_op) begin
        out_valid <= 1'b1;
        granted   <= '0;
        status    <= ST_OK;
        case (op_q)
          OP_LOAD: begin
            if (type_match) begin
              if (table_full) begin
                status <= ST_TABLE_FULL;
              end else begin
                used <= used + TUW'(1);
              end
            end
          end
          OP_ALLOC: begin
            if (fill_zero) begin
              status <= ST_OOM;
            end else begin
              fill    <= fill_dec;
              granted <= stk_rdata;
            end
          end
          OP_FREE: begin
            if (fill_full) begin
              status <= ST_STACK_FULL;
            end else begin
              fill <= fill + SFW'(1);
            end
          end
          default: begin
          end
        endcase
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.granted_page = granted;
  assign rsp.status       = status;

endmodule

`default_nettype wire

// ----- hw/rtl/pfsa_ctrl.sv -----
// Controller state machine of the page frame stack allocator.
// Depends on pfsa_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module pfsa_ctrl import pfsa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire pfsa_sts_t sts,
  output pfsa_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RLOAD  = 3'd2;
  localparam logic [2:0] S_RCALC  = 3'd3;
  localparam logic [2:0] S_RCLAMP = 3'd4;
  localparam logic [2:0] S_RPUSH  = 3'd5;
  localparam logic [2:0] S_POPRD  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       refilled;
  logic       refilled_next;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    refilled_next = refilled;
    unique case (state)
      S_IDLE: begin
        cmd.idle     = 1'b1;
        cmd.stack_rd = 1'b1;
        if (sts.accepted) begin
          refilled_next = 1'b0;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op_alloc && sts.fill_zero && !refilled) begin
          cmd.scan_start = 1'b1;
          state_next     = S_RLOAD;
        end else if (sts.slot_free) begin
          cmd.do_op  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RLOAD: begin
        if (sts.scan_end) begin
          state_next = S_POPRD;
        end else begin
          cmd.tbl_rd = 1'b1;
          state_next = S_RCALC;
        end
      end
      S_RCALC: begin
        cmd.calc   = 1'b1;
        state_next = S_RCLAMP;
      end
      S_RCLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_RPUSH;
      end
      S_RPUSH: begin
        if (sts.push_ok) begin
          cmd.push = 1'b1;
        end else if (sts.fill_full) begin
          state_next = S_POPRD;
        end else begin
          cmd.next_region = 1'b1;
          state_next      = S_RLOAD;
        end
      end
      S_POPRD: begin
        cmd.stack_rd  = 1'b1;
        refilled_next = 1'b1;
        state_next    = S_EXEC;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      refilled <= 1'b0;
    end else begin
      state    <= state_next;
      refilled <= refilled_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/page_frame_stack_allocator.sv -----
// Page frame stack allocator, top level. Load, free and a stack-served allocate are each
// accepted, then executed once the response register is free; a new request is taken only
// after the last one has executed. An allocate on an empty stack runs a refill scan first,
// pushing one page at a time (one stack memory write port). Synchronous active-high reset
// empties the stack and region table, zeroes the refill cursor and sets usable_type to 7.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_stack_allocator import pfsa_pkg::*; #(
  parameter int STACK_DEPTH      = STACK_DEPTH_DEF,
  parameter int MAX_REGIONS      = MAX_REGIONS_DEF,
  parameter int PAGE_NUMBER_BITS = PAGE_NUMBER_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [TYPE_BITS-1:0] cfg_wdata,
  pfsa_in_if.sink                   req,
  pfsa_out_if.source                rsp
);

  // The controller sequences each request; the datapath owns all storage and both
  // channels. They talk only through the command and status structs.
  pfsa_cmd_t cmd;
  pfsa_sts_t sts;

  // The controller is idle between requests and takes a transfer on req only then.
  // Each request then executes once the response register is free, so a response that
  // is still waiting never blocks the next request from being taken. An allocate that
  // finds the stack empty walks the region table from the first entry, pushes the pages
  // at or above the refill cursor, and then pops the top of the stack.
  pfsa_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // The stack and region table are memories with registered reads; their contents are
  // never used before being written, since the stack fill count and the region count
  // bound every read that matters.
  pfsa_dp #(
    .STACK_DEPTH      (STACK_DEPTH),
    .MAX_REGIONS      (MAX_REGIONS),
    .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ----- dv/page_frame_stack_allocator_tb.sv -----
// Self-checking testbench for the page frame stack allocator: region loads, page frees and
// allocations with refill passes, under random valid and ready gaps on both channels.
// Depends on pfsa_pkg, the pfsa_in_if / pfsa_out_if interfaces and the allocator top level.
`timescale 1ns / 1ps

module page_frame_stack_allocator_tb;
  import pfsa_pkg::*;

  localparam int PNB         = PAGE_NUMBER_BITS_DEF;
  localparam int STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int MAX_REGIONS = MAX_REGIONS_DEF;

  // The op field has one spare code, which the block treats as a no-op.
  localparam logic [OP_BITS-1:0] OP_NOP = 2'd3;

  localparam logic [PNB:0]   PAGE_SPACE = {1'b1, {PNB{1'b0}}};
  localparam logic [PNB-1:0] PAGE_MAX   = {PNB{1'b1}};

  localparam int     MAX_IDLE     = 18;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     PHASE_ITEMS  = 500;
  localparam int     REPORT_CAP   = 40;
  localparam longint LIMIT_NS     = 64'd100_000_000;

  typedef logic [PNB-1:0] page_t;

  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    page_t                page_number;
    logic [TYPE_BITS-1:0] region_type;
    page_t                region_base;
    page_t                region_pages;
  } alloc_req_t;

  typedef struct packed {
    page_t                  granted_page;
    logic [STATUS_BITS-1:0] status;
  } alloc_rsp_t;

  // Mirror of the allocator state plus the queue of responses still owed by the block.
  // Every request produces exactly one response, so the queue is a plain FIFO.
  class page_scoreboard;
    logic [TYPE_BITS-1:0] usable_type;
    page_t                stack_mem [STACK_DEPTH];
    int unsigned          fill;
    page_t                rgn_base [MAX_REGIONS];
    page_t                rgn_pages [MAX_REGIONS];
    int unsigned          rgn_count;
    logic [PNB:0]         cursor;
    page_t                last_grant;
    alloc_rsp_t           pending [$];
    int unsigned          errors;
    int unsigned          n_checked;
    int unsigned          n_granted;
    int unsigned          n_oom;
    int unsigned          n_stack_full;
    int unsigned          n_table_full;
    int unsigned          n_refills;

    function new();
      usable_type  = USABLE_TYPE_RST;
      fill         = 0;
      rgn_count    = 0;
      cursor       = '0;
      last_grant   = '0;
      errors       = 0;
      n_checked    = 0;
      n_granted    = 0;
      n_oom        = 0;
      n_stack_full = 0;
      n_table_full = 0;
      n_refills    = 0;
    endfunction

    function void report_mismatch(string msg);
      errors++;
      if (errors <= REPORT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
      else if (errors == REPORT_CAP + 1) $display("further mismatches are counted only");
    endfunction

    // Walk the regions in table order and push pages at or above the cursor until the
    // stack is full. Regions are clipped at the top of the page space.
    function void refill_stack();
      logic [PNB:0] lo;
      logic [PNB:0] hi;
      for (int r = 0; r < int'(rgn_count); r++) begin
        lo = {1'b0, rgn_base[r]};
        hi = {1'b0, rgn_base[r]} + {1'b0, rgn_pages[r]};
        if (hi > PAGE_SPACE) hi = PAGE_SPACE;
        if (lo < cursor) lo = cursor;
        while (lo < hi && fill < STACK_DEPTH) begin
          stack_mem[fill] = lo[PNB-1:0];
          fill++;
          lo++;
          cursor = lo;
        end
        if (fill >= STACK_DEPTH) break;
      end
      if (fill != 0) n_refills++;
    endfunction

    function void note_request(alloc_req_t item);
      alloc_rsp_t want;
      want.granted_page = '0;
      want.status       = ST_OK;
      case (item.op)
        OP_LOAD: begin
          if (item.region_type == usable_type) begin
            if (rgn_count >= MAX_REGIONS) begin
              want.status = ST_TABLE_FULL;
              n_table_full++;
            end else begin
              rgn_base[rgn_count]  = item.region_base;
              rgn_pages[rgn_count] = item.region_pages;
              rgn_count++;
            end
          end
        end
        OP_ALLOC: begin
          if (fill == 0) refill_stack();
          if (fill == 0) begin
            want.status = ST_OOM;
            n_oom++;
          end else begin
            fill--;
            want.granted_page = stack_mem[fill];
            last_grant        = stack_mem[fill];
            n_granted++;
          end
        end
        OP_FREE: begin
          if (fill >= STACK_DEPTH) begin
            want.status = ST_STACK_FULL;
            n_stack_full++;
          end else begin
            stack_mem[fill] = item.page_number;
            fill++;
          end
        end
        default: ;
      endcase
      pending.push_back(want);
    endfunction

    function void check_response(page_t got_page, logic [STATUS_BITS-1:0] got_status);
      alloc_rsp_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("response page %h status %0d with nothing outstanding",
                                  got_page, got_status));
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (got_status !== want.status)
        report_mismatch($sformatf("response %0d: status %0d, expected %0d",
                                  n_checked, got_status, want.status));
      if (got_page !== want.granted_page)
        report_mismatch($sformatf("response %0d: granted_page %h, expected %h",
                                  n_checked, got_page, want.granted_page));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [TYPE_BITS-1:0] cfg_wdata;

  pfsa_in_if  #(.PNB(PNB)) req_if ();
  pfsa_out_if #(.PNB(PNB)) rsp_if ();

  page_frame_stack_allocator #(
    .STACK_DEPTH      (STACK_DEPTH),
    .MAX_REGIONS      (MAX_REGIONS),
    .PAGE_NUMBER_BITS (PNB)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  page_scoreboard       sb = new();
  page_t                next_base;
  int                   n_sent;
  int                   send_mode;
  int                   recv_mode;
  logic [TYPE_BITS-1:0] last_type;

  // Idle behavior comes in three flavors, drawn anew every 64 transfers: no gaps at all,
  // a uniform random gap up to MAX_IDLE, and mostly back-to-back with an occasional gap.
  function automatic int draw_idle(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, MAX_IDLE);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_IDLE) : 0;
    endcase
  endfunction

  function automatic page_t rand_page();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[PNB-1:0];
  endfunction

  // Every request starts with random content in all fields, so fields the operation does
  // not use still see every bit toggle.
  function automatic alloc_req_t noise_item(logic [OP_BITS-1:0] op);
    alloc_req_t item;
    item.op           = op;
    item.page_number  = rand_page();
    item.region_type  = TYPE_BITS'($urandom_range(0, 15));
    item.region_base  = rand_page();
    item.region_pages = rand_page();
    return item;
  endfunction

  // Presents one request and returns at the edge where its transfer takes place. valid
  // stays high into the next request when no gap is drawn, and it is only ever written
  // once per time step.
  task automatic send_req(alloc_req_t item);
    int gap;
    if (n_sent % 64 == 0) send_mode = $urandom_range(0, 2);
    gap = draw_idle(send_mode);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= item.op;
    req_if.page_number  <= item.page_number;
    req_if.region_type  <= item.region_type;
    req_if.region_base  <= item.region_base;
    req_if.region_pages <= item.region_pages;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(item);
    n_sent++;
  endtask

  task automatic do_alloc();
    send_req(noise_item(OP_ALLOC));
  endtask

  task automatic do_free(page_t pg);
    alloc_req_t item;
    item             = noise_item(OP_FREE);
    item.page_number = pg;
    send_req(item);
  endtask

  task automatic do_load(logic [TYPE_BITS-1:0] ty, page_t base, page_t npages);
    alloc_req_t item;
    item              = noise_item(OP_LOAD);
    item.region_type  = ty;
    item.region_base  = base;
    item.region_pages = npages;
    send_req(item);
  endtask

  // Freed pages are either the page handed out most recently (which also produces double
  // frees) or an arbitrary page number.
  function automatic page_t pick_free_page();
    return ($urandom_range(0, 1) == 1) ? sb.last_grant : rand_page();
  endfunction

  // Loads a region whose size is mostly small, sometimes empty and sometimes larger than
  // the stack, so a refill stops part-way through it. Most regions follow the previous one
  // in address order; the rest land at a low base, below all the ascending ones.
  task automatic load_region(bit usable, bit ascending);
    page_t                base;
    page_t                npages;
    logic [TYPE_BITS-1:0] ty;
    int                   pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) npages = page_t'($urandom_range(1100, 1500));
    else if (pick == 1) npages = '0;
    else npages = page_t'($urandom_range(1, 24));
    if (usable) ty = sb.usable_type;
    else ty = sb.usable_type + TYPE_BITS'($urandom_range(1, 15));
    if (ascending) begin
      base      = next_base + page_t'($urandom_range(0, 16));
      next_base = base + npages;
    end else begin
      base = page_t'($urandom_range(0, 255));
    end
    do_load(ty, base, npages);
  endtask

  // Random traffic of short episodes: a few region loads, a run of allocations that can
  // drain the stack and trigger refills, a burst of frees, an even alloc/free mix or a no-op.
  task automatic run_random(int n_items);
    int  stop_at;
    int  kind;
    int  len;
    int  pick;
    bit  usable;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        len = $urandom_range(1, 3);
        repeat (len) begin
          // Keep two table slots free for the table-full sequence of the last phase.
          usable = ($urandom_range(0, 4) != 0) && (sb.rgn_count < MAX_REGIONS - 2);
          load_region(usable, $urandom_range(0, 7) != 0);
        end
      end else if (kind < 42) begin
        len = $urandom_range(1, 48);
        repeat (len) do_alloc();
      end else if (kind < 62) begin
        len = $urandom_range(1, 24);
        repeat (len) do_free(pick_free_page());
      end else if (kind < 97) begin
        len = $urandom_range(1, 32);
        repeat (len) begin
          pick = $urandom_range(0, 99);
          if (pick < 48) do_alloc();
          else if (pick < 96) do_free(pick_free_page());
          else send_req(noise_item(OP_NOP));
        end
      end else begin
        send_req(noise_item(OP_NOP));
      end
    end
  endtask

  // The register is only written with the block idle: valid is low and every response is back.
  task automatic write_usable_type(logic [TYPE_BITS-1:0] value);
    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.usable_type = value;
    cfg_we <= 1'b0;
  endtask

  // Response side: ready is stalled for a drawn number of cycles before each transfer and
  // every transfer is checked against the oldest outstanding expectation.
  initial begin : rsp_sink
    int stall;
    int n_rsp;
    n_rsp = 0;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (n_rsp % 64 == 0) recv_mode = $urandom_range(0, 2);
      stall = draw_idle(recv_mode);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      sb.check_response(rsp_if.granted_page, rsp_if.status);
      n_rsp++;
    end
  end

  initial begin : stimulus
    int n;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    req_if.valid        <= 1'b0;
    req_if.op           <= OP_NOP;
    req_if.page_number  <= '0;
    req_if.region_type  <= '0;
    req_if.region_base  <= '0;
    req_if.region_pages <= '0;
    next_base = page_t'(32'h100);
    n_sent    = 0;
    send_mode = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the usable type at its reset value.
    // An allocation with an empty stack and an empty table reports out of memory, and the
    // spare op code is a no-op.
    do_alloc();
    send_req(noise_item(OP_NOP));
    // Pages at both ends of the page space go through the stack unchanged, last in first out.
    do_free('0);
    do_free(PAGE_MAX);
    do_alloc();
    do_alloc();
    // A region of another type is ignored; an empty region is stored but yields nothing.
    do_load(USABLE_TYPE_RST - 4'd1, page_t'(32'h5), page_t'(32'h9));
    do_load(USABLE_TYPE_RST, page_t'(32'h10), '0);
    // The second region overlaps the first, so only its part above the cursor is used and
    // no page is handed out twice. Six allocations drain both, the last finds nothing.
    do_load(USABLE_TYPE_RST, page_t'(32'h20), page_t'(32'h3));
    do_load(USABLE_TYPE_RST, page_t'(32'h21), page_t'(32'h4));
    repeat (6) do_alloc();
    // A double free is accepted as is and the page comes back twice.
    do_free(page_t'(32'h20));
    do_free(page_t'(32'h20));
    do_alloc();
    do_alloc();
    do_load(4'hF, PAGE_MAX, PAGE_MAX);

    // Lowest type code.
    write_usable_type(4'h0);
    run_random(PHASE_ITEMS);

    // Highest type code. A region larger than the stack is loaded, up to 300 allocations drain
    // the stack, so the next one can refill it fully and the last two of three frees overflow.
    write_usable_type(4'hF);
    do_load(sb.usable_type, next_base, page_t'($urandom_range(1100, 1500)));
    next_base = next_base + page_t'(32'd1600);
    n = 0;
    while (sb.fill != 0 && n < 300) begin
      do_alloc();
      n++;
    end
    do_alloc();
    repeat (3) do_free(rand_page());
    run_random(PHASE_ITEMS);

    // A middle type code. The table is filled with regions of random placement and size,
    // the last one reaching past the top of the page space, and then overflowed.
    last_type = TYPE_BITS'($urandom_range(1, 14));
    write_usable_type(last_type);
    while (sb.rgn_count < MAX_REGIONS - 1) do_load(sb.usable_type, rand_page(), rand_page());
    do_load(sb.usable_type, PAGE_MAX - page_t'(32'd4), PAGE_MAX);
    repeat (3) do_load(sb.usable_type, rand_page(), rand_page());
    run_random(PHASE_ITEMS);
    req_if.valid <= 1'b0;

    // Let the outstanding responses come back, then allow some quiet cycles so that any
    // extra response still gets flagged.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d pages granted, %0d refill passes, %0d regions stored",
             n_sent, sb.n_granted, sb.n_refills, sb.rgn_count);
    $display("out of memory %0d, stack full %0d, table full %0d; usable types 7, 0, 15, %0d",
             sb.n_oom, sb.n_stack_full, sb.n_table_full, last_type);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pfsa_pkg.sv
hw/rtl/pfsa_if.sv
hw/rtl/pfsa_ram.sv
hw/rtl/pfsa_dp.sv
hw/rtl/pfsa_ctrl.sv
hw/rtl/page_frame_stack_allocator.sv
dv/page_frame_stack_allocator_tb.sv
